// ===== src/tdl_pkg.sv =====
// ============================================================================
// tdl_pkg: shared types and constants for the tree distance block
// Sizes of the Euler tour store, segment tree and node table, command codes,
// and the word formats passed between the front and back ends.
// ============================================================================
package tdl_pkg;

  localparam int NODE_W    = 10;
  localparam int MAX_NODES = 1 << NODE_W;
  localparam int LEAF_W    = 11;
  localparam int LEAVES    = 1 << LEAF_W;
  localparam int TREE_AW   = LEAF_W + 1;
  localparam int CNT_W     = LEAF_W + 1;
  localparam int DEPTH_W   = 10;
  localparam int ENTRY_W   = DEPTH_W + NODE_W;
  localparam int DIST_W    = 11;
  localparam int QUEUE_AW  = 2;

  localparam logic [ENTRY_W-1:0] ENTRY_INF = '1;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // One command word as queued between front and back end
  typedef struct packed {
    logic               command;
    logic [NODE_W-1:0]  node_a;
    logic [NODE_W-1:0]  node_b;
    logic [DEPTH_W-1:0] entry_depth;
  } cmd_t;

  // One result word
  typedef struct packed {
    logic               overflowed;
    logic               unknown_node;
    logic [NODE_W-1:0]  ancestor_node;
    logic [DIST_W-1:0]  distance;
  } res_t;

  // Node table entry: seen mark, first tour index, depth at first occurrence
  typedef struct packed {
    logic               seen;
    logic [LEAF_W-1:0]  first_idx;
    logic [DEPTH_W-1:0] depth;
  } node_ent_t;

endpackage

// ===== src/tdl_front.sv =====
// ============================================================================
// tdl_front: command intake queue
// Accepts command words and holds them in a short queue so the back end
// can stall without blocking the input side.
// ============================================================================
module tdl_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  tdl_pkg::cmd_t in_cmd,
  output logic          q_valid,
  input  logic          q_pop,
  output tdl_pkg::cmd_t q_cmd
);

  localparam int DEPTH = 1 << tdl_pkg::QUEUE_AW;

  tdl_pkg::cmd_t                 slot_r [DEPTH];
  logic [tdl_pkg::QUEUE_AW-1:0]  wr_r, wr_nxt;
  logic [tdl_pkg::QUEUE_AW-1:0]  rd_r, rd_nxt;
  logic [tdl_pkg::QUEUE_AW:0]    cnt_r, cnt_nxt;
  logic                          push, pop;

  assign in_ready = (cnt_r != (tdl_pkg::QUEUE_AW+1)'(DEPTH));
  assign q_valid  = (cnt_r != '0);
  assign q_cmd    = slot_r[rd_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && q_valid;

  // Advance pointers and occupancy
  always_comb begin
    wr_nxt  = push ? wr_r + 1'b1 : wr_r;
    rd_nxt  = pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r + {{tdl_pkg::QUEUE_AW{1'b0}}, push}
                    - {{tdl_pkg::QUEUE_AW{1'b0}}, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Store incoming word
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_r] <= in_cmd;
    end
  end

endmodule

// ===== src/tdl_engine.sv =====
// ============================================================================
// tdl_engine: segment tree and node table back end
// Clears its memories after reset, then executes tour loads (leaf write and
// climb to the root) and distance queries (range minimum, ancestor lookup).
// ============================================================================
module tdl_engine (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  output logic          q_pop,
  input  tdl_pkg::cmd_t q_cmd,
  output logic          out_valid,
  input  logic          out_ready,
  output tdl_pkg::res_t out_res
);

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_LCHK, ST_LCLIMB,
    ST_QIDX, ST_QRMQ, ST_QANC, ST_QDEP, ST_QOUT
  } state_t;

  localparam int AW = tdl_pkg::TREE_AW;
  localparam int EW = tdl_pkg::ENTRY_W;
  localparam int NW = tdl_pkg::NODE_W;
  localparam int DW = tdl_pkg::DEPTH_W;
  localparam int LW = tdl_pkg::LEAF_W;

  // Memories
  logic [EW-1:0]       tree_mem [1 << AW];
  tdl_pkg::node_ent_t  node_mem [tdl_pkg::MAX_NODES];

  logic                tree_we;
  logic [AW-1:0]       tree_wa, tree_ra, tree_rb;
  logic [EW-1:0]       tree_wd, tree_qa, tree_qb;
  logic                node_we;
  logic [NW-1:0]       node_wa, node_ra, node_rb;
  tdl_pkg::node_ent_t  node_wd, node_qa, node_qb;

  // Control and datapath registers
  state_t              state_r, state_nxt;
  logic [AW-1:0]       clr_r, clr_nxt;
  logic [tdl_pkg::CNT_W-1:0] tc_r, tc_nxt;
  logic                ovf_r, ovf_nxt;
  tdl_pkg::cmd_t       cmd_r, cmd_nxt;
  logic [EW-1:0]       cur_r, cur_nxt;
  logic [AW-1:0]       pos_r, pos_nxt;
  logic [AW:0]         l_r, l_nxt;
  logic [AW-1:0]       r_r, r_nxt;
  logic                pa_r, pa_nxt, pb_r, pb_nxt;
  logic [EW-1:0]       res_r, res_nxt;
  logic [DW-1:0]       da_r, da_nxt, db_r, db_nxt;
  tdl_pkg::res_t       pend_r, pend_nxt;
  logic                out_valid_r, out_valid_nxt;
  tdl_pkg::res_t       out_res_r, out_res_nxt;

  // Scratch values
  logic [EW-1:0]       leaf_val, min_sib, acc_a, acc_b, acc;
  logic [AW-1:0]       leaf_pos, par;
  logic [LW-1:0]       lo, hi;
  logic                going;
  logic [DW-1:0]       anc_depth;
  logic [DW:0]         dsum, dtwice;

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    tc_nxt        = tc_r;
    ovf_nxt       = ovf_r;
    cmd_nxt       = cmd_r;
    cur_nxt       = cur_r;
    pos_nxt       = pos_r;
    l_nxt         = l_r;
    r_nxt         = r_r;
    pa_nxt        = pa_r;
    pb_nxt        = pb_r;
    res_nxt       = res_r;
    da_nxt        = da_r;
    db_nxt        = db_r;
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_res_nxt   = out_res_r;
    q_pop         = 1'b0;

    tree_we = 1'b0;
    tree_wa = clr_r;
    tree_wd = tdl_pkg::ENTRY_INF;
    tree_ra = '0;
    tree_rb = '0;
    node_we = 1'b0;
    node_wa = clr_r[NW-1:0];
    node_wd = '0;
    node_ra = q_cmd.node_a;
    node_rb = q_cmd.node_b;

    leaf_pos  = {1'b1, tc_r[LW-1:0]};
    leaf_val  = {cmd_r.entry_depth, cmd_r.node_a};
    min_sib   = (tree_qa < cur_r) ? tree_qa : cur_r;
    par       = pos_r >> 1;
    acc_a     = pa_r ? tree_qa : tdl_pkg::ENTRY_INF;
    acc_b     = pb_r ? tree_qb : tdl_pkg::ENTRY_INF;
    acc       = (acc_a < res_r) ? acc_a : res_r;
    acc       = (acc_b < acc) ? acc_b : acc;
    going     = (l_r <= {1'b0, r_r}) && (r_r != '0);
    lo        = (node_qa.first_idx < node_qb.first_idx) ? node_qa.first_idx
                                                        : node_qb.first_idx;
    hi        = (node_qa.first_idx < node_qb.first_idx) ? node_qb.first_idx
                                                        : node_qa.first_idx;
    anc_depth = node_qa.seen ? node_qa.depth : res_r[EW-1:NW];
    dsum      = {1'b0, da_r} + {1'b0, db_r};
    dtwice    = {anc_depth, 1'b0};

    unique case (state_r)
      // Sweep both memories to their reset contents
      ST_CLEAR: begin
        tree_we = 1'b1;
        node_we = 1'b1;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == '1) begin
          state_nxt = ST_IDLE;
        end
      end
      // Take the next command, start the node table reads
      ST_IDLE: begin
        if (q_valid) begin
          q_pop   = 1'b1;
          cmd_nxt = q_cmd;
          if (q_cmd.command == tdl_pkg::CMD_QUERY) begin
            state_nxt = ST_QIDX;
          end else if (tc_r[tdl_pkg::CNT_W-1]) begin
            ovf_nxt = 1'b1;
          end else begin
            state_nxt = ST_LCHK;
          end
        end
      end
      // Record first occurrence, write the leaf, read its sibling
      ST_LCHK: begin
        if (!node_qa.seen) begin
          node_we = 1'b1;
          node_wa = cmd_r.node_a;
          node_wd = '{seen: 1'b1, first_idx: tc_r[LW-1:0],
                      depth: cmd_r.entry_depth};
        end
        tree_we   = 1'b1;
        tree_wa   = leaf_pos;
        tree_wd   = leaf_val;
        tree_ra   = leaf_pos ^ AW'(1);
        pos_nxt   = leaf_pos;
        cur_nxt   = leaf_val;
        state_nxt = ST_LCLIMB;
      end
      // One tree level a cycle toward the root
      ST_LCLIMB: begin
        tree_we = 1'b1;
        tree_wa = par;
        tree_wd = min_sib;
        tree_ra = par ^ AW'(1);
        cur_nxt = min_sib;
        pos_nxt = par;
        if (par == AW'(1)) begin
          tc_nxt    = tc_r + 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      // Check both nodes and set up the range
      ST_QIDX: begin
        if (!node_qa.seen || !node_qb.seen) begin
          pend_nxt  = '{overflowed: 1'b0, unknown_node: 1'b1,
                        ancestor_node: '0, distance: '0};
          state_nxt = ST_QOUT;
        end else begin
          l_nxt     = {2'b01, lo};
          r_nxt     = {1'b1, hi};
          pa_nxt    = 1'b0;
          pb_nxt    = 1'b0;
          res_nxt   = tdl_pkg::ENTRY_INF;
          da_nxt    = node_qa.depth;
          db_nxt    = node_qb.depth;
          state_nxt = ST_QRMQ;
        end
      end
      // Range minimum: issue up to two reads a level, fold returned data
      ST_QRMQ: begin
        res_nxt = acc;
        if (going) begin
          tree_ra = l_r[AW-1:0];
          tree_rb = r_r;
          pa_nxt  = l_r[0];
          pb_nxt  = !r_r[0];
          l_nxt   = (l_r + {{AW{1'b0}}, l_r[0]}) >> 1;
          r_nxt   = (r_r - {{(AW-1){1'b0}}, !r_r[0]}) >> 1;
        end else begin
          pa_nxt    = 1'b0;
          pb_nxt    = 1'b0;
          state_nxt = ST_QANC;
        end
      end
      // Look up the ancestor's first-occurrence depth
      ST_QANC: begin
        node_ra   = res_r[NW-1:0];
        state_nxt = ST_QDEP;
      end
      // Form the distance, clamp at zero
      ST_QDEP: begin
        pend_nxt.overflowed    = 1'b0;
        pend_nxt.unknown_node  = 1'b0;
        pend_nxt.ancestor_node = res_r[NW-1:0];
        pend_nxt.distance      = (dsum < dtwice) ? '0 : (dsum - dtwice);
        state_nxt              = ST_QOUT;
      end
      // Hand the result to the output register once it is free
      ST_QOUT: begin
        if (!out_valid_r || out_ready) begin
          out_res_nxt            = pend_r;
          out_res_nxt.overflowed = ovf_r;
          out_valid_nxt          = 1'b1;
          state_nxt              = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  // Control state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      tc_r        <= '0;
      ovf_r       <= 1'b0;
      pa_r        <= 1'b0;
      pb_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      tc_r        <= tc_nxt;
      ovf_r       <= ovf_nxt;
      pa_r        <= pa_nxt;
      pb_r        <= pb_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    cur_r     <= cur_nxt;
    pos_r     <= pos_nxt;
    l_r       <= l_nxt;
    r_r       <= r_nxt;
    res_r     <= res_nxt;
    da_r      <= da_nxt;
    db_r      <= db_nxt;
    pend_r    <= pend_nxt;
    out_res_r <= out_res_nxt;
  end

  // Segment tree memory: one write, two registered reads
  always_ff @(posedge clk) begin
    if (tree_we) begin
      tree_mem[tree_wa] <= tree_wd;
    end
    tree_qa <= tree_mem[tree_ra];
    tree_qb <= tree_mem[tree_rb];
  end

  // Node table memory: one write, two registered reads
  always_ff @(posedge clk) begin
    if (node_we) begin
      node_mem[node_wa] <= node_wd;
    end
    node_qa <= node_mem[node_ra];
    node_qb <= node_mem[node_rb];
  end

endmodule

// ===== src/tree_distance_lca_rmq.sv =====
// ============================================================================
// tree_distance_lca_rmq: tree distance through lowest common ancestor
// Loads an Euler tour into a min segment tree and answers distance queries.
// ============================================================================
// Usage:
//   Input words arrive on in_*; in_tuser selects load (0) or query (1).
//   A load stores one (node, depth) tour entry and gives no result; a query
//   returns one word on out_* with distance, ancestor, unknown and overflow.
//   Words pass through a four-deep command queue, so the input keeps
//   accepting while the back end works or a result waits on out_tready.
//   Steps: a load runs in the back end as dispatch, leaf write and
//   eleven climb steps, one tree level per cycle on the tree memory write
//   port. A query runs node lookup, the range-minimum walk (two tree
//   reads a level) and the ancestor lookup; when a node is unknown it
//   skips the walk and the ancestor lookup.
//   After reset the block clears its memories, one tree entry per cycle,
//   before the first command runs; words are queued meanwhile. A stalled
//   result holds in the output register and the back end waits behind
//   it, then the queue fills and in_tready drops.
//   Loads past 2048 entries are dropped and set the sticky overflow bit.
// ============================================================================
module tree_distance_lca_rmq (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // node_a[9:0], node_b[19:10], entry_depth[29:20]
  input  logic        in_tuser,   // command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // distance[10:0], ancestor_node[20:11],
                                  // unknown_node[21], overflowed[22]
);

  tdl_pkg::cmd_t in_cmd, q_cmd;
  tdl_pkg::res_t res;
  logic          q_valid, q_pop;

  // Unpack the input word
  always_comb begin
    in_cmd.command     = in_tuser;
    in_cmd.node_a      = in_tdata[9:0];
    in_cmd.node_b      = in_tdata[19:10];
    in_cmd.entry_depth = in_tdata[29:20];
  end

  tdl_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_cmd   (in_cmd),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_cmd    (q_cmd)
  );

  tdl_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_cmd     (q_cmd),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  // Pack the result word
  assign out_tdata = {1'b0, res.overflowed, res.unknown_node,
                      res.ancestor_node, res.distance};

endmodule
